### hw/rtl/esp_pkg.sv
// Package for the EBML stream parser: event codes, parse phases, result and
// control types, and small decoding functions. No dependencies.
package esp_pkg;

    localparam int NUM_MASTER  = 7;
    localparam int MAX_RESULTS = 10;
    localparam int ID_W        = 56;
    localparam int CFG_IDX_W   = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_MASTER_MASK = 3'd7;

    localparam logic [2:0] KIND_OPEN    = 3'd0;
    localparam logic [2:0] KIND_CONTENT = 3'd1;
    localparam logic [2:0] KIND_EMPTY   = 3'd2;
    localparam logic [2:0] KIND_CLOSE   = 3'd3;
    localparam logic [2:0] KIND_ERROR   = 3'd4;

    localparam logic [1:0] PH_ID      = 2'd0;
    localparam logic [1:0] PH_SIZE    = 2'd1;
    localparam logic [1:0] PH_CONTENT = 2'd2;

    typedef logic [NUM_MASTER-1:0][ID_W-1:0] t_id_tab;

    typedef struct packed {
        logic [2:0]      kind;
        logic [ID_W-1:0] id;
        logic [ID_W-1:0] size;
        logic            master;
        logic [7:0]      data;
        logic            lastc;
        logic [3:0]      depth;
        logic            last;
    } t_result;

    typedef struct packed {
        logic take;
        logic step;
        logic emit1;
        logic emit2;
        logic cread;
        logic cpop;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic ev1_v;
        logic ev2_v;
        logic casc;
        logic cas_go;
        logic top_close;
        logic pend_v;
        logic emit_ok;
    } t_stat;

    function automatic logic [3:0] code_len(input logic [7:0] b);
        logic [3:0] n;
        n = 4'd8;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                n = 4'(8 - i);
            end
        end
        return n;
    endfunction

    function automatic logic [ID_W-1:0] code_mask(input logic [3:0] len);
        logic [ID_W-1:0] m;
        m = '0;
        for (int i = 0; i < 8; i++) begin
            if (4'(i) < len) begin
                m[7*i +: 7] = 7'h7F;
            end
        end
        return m;
    endfunction

    function automatic logic match_master(input logic [ID_W-1:0] id, input t_id_tab tab,
                                          input logic [NUM_MASTER-1:0] en);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < NUM_MASTER; i++) begin
            if (en[i] && tab[i] == id) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

### hw/rtl/esp_in_if.sv
// Input channel of the EBML stream parser: one stream byte per transaction.
// Depends on nothing.
interface esp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink (input valid, input stream_byte, output ready);
endinterface

### hw/rtl/esp_out_if.sv
// Output channel of the EBML stream parser: one parse event per transaction.
// Depends on nothing.
interface esp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_kind;
    logic [55:0] element_id;
    logic [55:0] content_size;
    logic        is_master;
    logic [7:0]  data_byte;
    logic        last_content;
    logic [3:0]  nesting_depth;
    logic        last_result;

    modport source (output valid, output event_kind, output element_id, output content_size,
                    output is_master, output data_byte, output last_content,
                    output nesting_depth, output last_result, input ready);
    modport sink (input valid, input event_kind, input element_id, input content_size,
                  input is_master, input data_byte, input last_content,
                  input nesting_depth, input last_result, output ready);
endinterface

### hw/rtl/ebml_stream_parser_core.sv
// Top level of the EBML stream parser: joins the controller and the datapath
// to the input and output channels. Depends on esp_pkg and both interfaces.
//
// Usage: stream bytes enter on i_in, one byte per transaction. Each byte
// yields zero to ten events on o_out (open, content byte, empty content,
// close, error); last_result marks the final event of a byte. The master
// identifier table is written through i_cfg_we, i_cfg_idx and i_cfg_wdata;
// the user must write it only while the block is idle, which the block does
// not enforce. Indexes 0 to 6 hold identifiers, index 7 the enable mask.
// A new byte is taken only once the previous one is finished. The close
// cascade walks the nesting stack one entry at a time, reading each entry
// and then checking it, and ends on an empty stack, the event limit or an
// entry that is not yet closed. The last event is held back until the byte
// is finished, so that it can be marked. A stalled receiver holds the
// output register and the controller waits; no event is lost. Reset empties
// the stack, clears the table and returns parsing to the identifier phase.
module ebml_stream_parser_core #(
    parameter int MAX_DEPTH = 8,
    parameter int SIZE_BITS = 56
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [esp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [esp_pkg::ID_W-1:0]      i_cfg_wdata,
    esp_in_if.sink                        i_in,
    esp_out_if.source                     o_out
);
    import esp_pkg::*;

    t_cmd    cmd;
    t_stat   stat;
    t_result res;
    logic    out_valid;

    esp_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    esp_datapath #(
        .MAX_DEPTH (MAX_DEPTH),
        .SIZE_BITS (SIZE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_byte   (i_in.stream_byte),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (o_out.ready),
        .o_out_valid (out_valid),
        .o_result    (res)
    );

    assign o_out.valid         = out_valid;
    assign o_out.event_kind    = res.kind;
    assign o_out.element_id    = res.id;
    assign o_out.content_size  = res.size;
    assign o_out.is_master     = res.master;
    assign o_out.data_byte     = res.data;
    assign o_out.last_content  = res.lastc;
    assign o_out.nesting_depth = res.depth;
    assign o_out.last_result   = res.last;

endmodule

### hw/rtl/esp_datapath.sv
// Datapath of the EBML stream parser: code decoding, nesting stack, master
// table, event staging and output register. Depends on esp_pkg.
module esp_datapath #(
    parameter int MAX_DEPTH = 8,
    parameter int SIZE_BITS = 56
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [esp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [esp_pkg::ID_W-1:0]        i_cfg_wdata,
    input  logic [7:0]                      i_in_byte,
    input  esp_pkg::t_cmd                   i_cmd,
    output esp_pkg::t_stat                  o_stat,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output esp_pkg::t_result                o_result
);
    import esp_pkg::*;

    localparam int CW = $clog2(MAX_DEPTH + 1);
    localparam int IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    t_id_tab               r_tab;
    logic [NUM_MASTER-1:0] r_en;

    logic [7:0]           r_byte;
    logic [1:0]           r_phase,  n_phase;
    logic [ID_W-1:0]      r_acc,    n_acc;
    logic [3:0]           r_len,    n_len;
    logic [3:0]           r_seen,   n_seen;
    logic [ID_W-1:0]      r_held,   n_held;
    logic [CW-1:0]        r_cnt,    n_cnt;
    logic [SIZE_BITS-1:0] r_g,      n_g;
    logic [ID_W-1:0]      r_leaf_id,   n_leaf_id;
    logic [SIZE_BITS-1:0] r_leaf_size, n_leaf_size;
    logic [SIZE_BITS-1:0] r_leaf_left, n_leaf_left;
    logic                 r_ev1_v,  n_ev1_v;
    logic                 r_ev2_v,  n_ev2_v;
    logic                 r_casc,   n_casc;
    t_result              r_ev,     n_ev;
    logic                 push;

    logic [ID_W-1:0]      r_stk_id    [MAX_DEPTH];
    logic [SIZE_BITS-1:0] r_stk_size  [MAX_DEPTH];
    logic [SIZE_BITS-1:0] r_stk_start [MAX_DEPTH];
    logic [ID_W-1:0]      r_top_id;
    logic [SIZE_BITS-1:0] r_top_size;
    logic [SIZE_BITS-1:0] r_top_start;

    logic [3:0]           r_nres;
    t_result              r_pend;
    logic                 r_pend_v;
    t_result              r_out;
    logic                 r_out_v;

    t_result              new_res;
    t_result              pend_last;
    logic                 emit_any;
    logic                 out_free;
    logic                 held_master;
    logic [IW-1:0]        top_idx;

    function automatic logic [3:0] depth_of(input logic [CW-1:0] c);
        logic [31:0] w;
        w = 32'(c);
        return w[3:0];
    endfunction

    assign held_master = match_master(r_held, r_tab, r_en);
    assign top_idx     = IW'(r_cnt - CW'(1));

    always_comb begin
        logic [3:0]      len;
        logic [3:0]      seen;
        logic [ID_W-1:0] acc;
        logic [ID_W-1:0] value;
        logic [SIZE_BITS-1:0] size;
        logic [1:0]      ph;
        logic            fin;
        n_phase = r_phase;
        n_acc = r_acc;
        n_len = r_len;
        n_seen = r_seen;
        n_held = r_held;
        n_cnt = r_cnt;
        n_g = r_g;
        n_leaf_id = r_leaf_id;
        n_leaf_size = r_leaf_size;
        n_leaf_left = r_leaf_left;
        n_ev1_v = r_ev1_v;
        n_ev2_v = r_ev2_v;
        n_casc = r_casc;
        n_ev = r_ev;
        push = 1'b0;
        len = '0;
        seen = '0;
        acc = '0;
        value = '0;
        size = '0;
        ph = PH_ID;
        fin = 1'b0;
        if (i_cmd.step) begin
            n_ev1_v = 1'b0;
            n_ev2_v = 1'b0;
            n_casc = 1'b1;
            n_ev = '0;
            if (r_phase == PH_CONTENT && r_cnt != '0) begin
                fin = (r_leaf_left == SIZE_BITS'(1));
                n_g = r_g + SIZE_BITS'(1);
                n_leaf_left = r_leaf_left - SIZE_BITS'(1);
                n_ev1_v = 1'b1;
                n_ev.kind = KIND_CONTENT;
                n_ev.id = r_leaf_id;
                n_ev.size = ID_W'(r_leaf_size);
                n_ev.data = r_byte;
                n_ev.lastc = fin;
                n_ev.depth = depth_of(r_cnt);
                if (fin) begin
                    n_phase = PH_ID;
                end
            end else begin
                ph = (r_phase == PH_SIZE) ? PH_SIZE : PH_ID;
                n_phase = ph;
                if (r_seen == '0 && r_byte == 8'd0) begin
                    n_ev1_v = 1'b1;
                    n_ev.kind = KIND_ERROR;
                    n_ev.depth = depth_of(r_cnt);
                    n_phase = PH_ID;
                    n_acc = '0;
                    n_len = '0;
                end else begin
                    len = (r_seen == '0) ? code_len(r_byte) : r_len;
                    acc = {((r_seen == '0) ? 48'd0 : r_acc[ID_W-9:0]), r_byte};
                    seen = r_seen + 4'd1;
                    if (seen >= len) begin
                        value = acc & code_mask(len);
                        n_seen = '0;
                        n_len = '0;
                        n_acc = '0;
                        n_g = r_g + SIZE_BITS'(len);
                        if (ph == PH_ID) begin
                            n_held = value;
                            n_phase = PH_SIZE;
                        end else begin
                            size = value[SIZE_BITS-1:0];
                            n_phase = PH_ID;
                            n_ev1_v = 1'b1;
                            n_ev.id = r_held;
                            n_ev.size = ID_W'(size);
                            n_ev.master = held_master;
                            if (32'(r_cnt) >= MAX_DEPTH) begin
                                n_ev.kind = KIND_ERROR;
                                n_ev.depth = depth_of(r_cnt);
                            end else begin
                                push = 1'b1;
                                n_cnt = r_cnt + CW'(1);
                                n_ev.kind = KIND_OPEN;
                                n_ev.depth = depth_of(r_cnt + CW'(1));
                                if (!held_master) begin
                                    if (size != '0) begin
                                        n_phase = PH_CONTENT;
                                        n_casc = 1'b0;
                                        n_leaf_id = r_held;
                                        n_leaf_size = size;
                                        n_leaf_left = size;
                                    end else begin
                                        n_ev2_v = 1'b1;
                                    end
                                end
                            end
                        end
                    end else begin
                        n_seen = seen;
                        n_len = len;
                        n_acc = acc;
                    end
                end
            end
        end else if (i_cmd.cpop) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_comb begin
        new_res = '0;
        if (i_cmd.emit1) begin
            new_res = r_ev;
            new_res.last = 1'b0;
        end else if (i_cmd.emit2) begin
            new_res.kind = KIND_EMPTY;
            new_res.id = r_ev.id;
            new_res.depth = r_ev.depth;
        end else begin
            new_res.kind = KIND_CLOSE;
            new_res.id = r_top_id;
            new_res.size = ID_W'(r_top_size);
            new_res.master = match_master(r_top_id, r_tab, r_en);
            new_res.depth = depth_of(r_cnt - CW'(1));
        end
    end

    always_comb begin
        pend_last = r_pend;
        pend_last.last = 1'b1;
    end

    assign emit_any = i_cmd.emit1 | i_cmd.emit2 | i_cmd.cpop;
    assign out_free = !r_out_v || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tab <= '0;
            r_en <= '0;
            r_phase <= PH_ID;
            r_acc <= '0;
            r_len <= '0;
            r_seen <= '0;
            r_held <= '0;
            r_cnt <= '0;
            r_g <= '0;
            r_ev1_v <= 1'b0;
            r_ev2_v <= 1'b0;
            r_casc <= 1'b0;
            r_nres <= '0;
            r_pend_v <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MASTER_MASK: r_en <= i_cfg_wdata[NUM_MASTER-1:0];
                    default: r_tab[i_cfg_idx] <= i_cfg_wdata;
                endcase
            end
            r_phase <= n_phase;
            r_acc <= n_acc;
            r_len <= n_len;
            r_seen <= n_seen;
            r_held <= n_held;
            r_cnt <= n_cnt;
            r_g <= n_g;
            r_ev1_v <= n_ev1_v;
            r_ev2_v <= n_ev2_v;
            r_casc <= n_casc;
            if (i_cmd.step) begin
                r_nres <= '0;
            end else if (emit_any) begin
                r_nres <= r_nres + 4'd1;
            end
            if (emit_any) begin
                r_pend_v <= 1'b1;
                if (r_pend_v) begin
                    r_out_v <= 1'b1;
                end else if (i_out_ready) begin
                    r_out_v <= 1'b0;
                end
            end else if (i_cmd.flush && r_pend_v) begin
                r_pend_v <= 1'b0;
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_byte <= i_in_byte;
        end
        r_ev <= n_ev;
        r_leaf_id <= n_leaf_id;
        r_leaf_size <= n_leaf_size;
        r_leaf_left <= n_leaf_left;
        if (push) begin
            r_stk_id[IW'(r_cnt)] <= r_held;
            r_stk_size[IW'(r_cnt)] <= n_ev.size[SIZE_BITS-1:0];
            r_stk_start[IW'(r_cnt)] <= n_g;
        end
        if (i_cmd.cread) begin
            r_top_id <= r_stk_id[top_idx];
            r_top_size <= r_stk_size[top_idx];
            r_top_start <= r_stk_start[top_idx];
        end
        if (emit_any) begin
            r_pend <= new_res;
            if (r_pend_v) begin
                r_out <= r_pend;
            end
        end else if (i_cmd.flush && r_pend_v) begin
            r_out <= pend_last;
        end
    end

    assign o_stat.ev1_v     = r_ev1_v;
    assign o_stat.ev2_v     = r_ev2_v;
    assign o_stat.casc      = r_casc;
    assign o_stat.cas_go    = (r_cnt != '0) && (r_nres < 4'(MAX_RESULTS));
    assign o_stat.top_close = (r_top_size == '0) || ((r_g - r_top_start) == r_top_size);
    assign o_stat.pend_v    = r_pend_v;
    assign o_stat.emit_ok   = !r_pend_v || out_free;

    assign o_out_valid = r_out_v;
    assign o_result    = r_out;

endmodule

### hw/rtl/esp_controller.sv
// Sequencing state machine of the EBML stream parser: takes a byte, steps the
// decoder, emits staged events and walks the close cascade. Depends on esp_pkg.
module esp_controller (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  esp_pkg::t_stat i_stat,
    output esp_pkg::t_cmd  o_cmd
);
    import esp_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_STEP  = 3'd1;
    localparam logic [2:0] S_EV1   = 3'd2;
    localparam logic [2:0] S_EV2   = 3'd3;
    localparam logic [2:0] S_CREAD = 3'd4;
    localparam logic [2:0] S_CCHK  = 3'd5;
    localparam logic [2:0] S_FLUSH = 3'd6;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                o_cmd.step = 1'b1;
                n_state = S_EV1;
            end
            S_EV1: begin
                if (!i_stat.ev1_v) begin
                    n_state = S_EV2;
                end else if (i_stat.emit_ok) begin
                    o_cmd.emit1 = 1'b1;
                    n_state = S_EV2;
                end
            end
            S_EV2: begin
                if (!i_stat.ev2_v || i_stat.emit_ok) begin
                    o_cmd.emit2 = i_stat.ev2_v;
                    n_state = i_stat.casc ? S_CREAD : S_FLUSH;
                end
            end
            S_CREAD: begin
                if (i_stat.cas_go) begin
                    o_cmd.cread = 1'b1;
                    n_state = S_CCHK;
                end else begin
                    n_state = S_FLUSH;
                end
            end
            S_CCHK: begin
                if (!i_stat.top_close) begin
                    n_state = S_FLUSH;
                end else if (i_stat.emit_ok) begin
                    o_cmd.cpop = 1'b1;
                    n_state = S_CREAD;
                end
            end
            S_FLUSH: begin
                if (!i_stat.pend_v || i_stat.emit_ok) begin
                    o_cmd.flush = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
